// ===== hdl/grouped_sorted_list_engine_defines.svh =====
// ----------------------------------------------------------------------------
// Grouped sorted list engine: assertion macros
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef GROUPED_SORTED_LIST_ENGINE_DEFINES_SVH
`define GROUPED_SORTED_LIST_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
`define GSLE_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gsle assertion failed");
`define GSLE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gsle assertion failed");
`else
`define GSLE_ASSERT(label, ante, cons)
`define GSLE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== hdl/gsle_pkg.sv =====
// ----------------------------------------------------------------------------
// gsle_pkg
// Shared constants and types of the grouped sorted list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package gsle_pkg;

  localparam int unsigned NUM_GROUPS_DEF     = 4;
  localparam int unsigned GROUP_CAPACITY_DEF = 8;
  localparam int unsigned CODE_BITS_DEF      = 16;

  localparam int unsigned GROUP_SEL_W = 2;
  localparam int unsigned CODE_VAL_W  = 16;
  localparam int unsigned REMOVED_W   = 3;
  localparam int unsigned FILL_W      = 4;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } req_e;

  typedef enum logic {
    ST_DONE = 1'b0,
    ST_FULL = 1'b1
  } status_e;

  // per-cycle command from a row to its cells
  typedef struct packed {
    logic ins_en;
    logic rem_en;
  } cell_ctl_t;

  // row status back to the top level
  typedef struct packed {
    logic full;
    logic hit;
  } row_stat_t;

endpackage

`default_nettype wire

// ===== hdl/grouped_sorted_list_engine.sv =====
// ----------------------------------------------------------------------------
// grouped_sorted_list_engine
// Fixed set of groups, each an ascending list of codes held in a chain of
// cells. Insert into one group, remove first match from all groups.
//
//   channel  dir  handshake                fields
//   in       in   in_valid_i / in_ready_o  req_type_i group_sel_i code_value_i
//   out      out  out_valid_o / out_ready_i status_o removed_count_o group_fill_o
//
// One item per cycle unless out_ready_i holds a result: every cell compares
// against the code in parallel and shifts by one slot in the same cycle; the
// result is registered, and out_valid_o rises in the cycle after accept.
// Reset clears all counts and occupied flags at once; no clearing pass.
// While a result is held by out_ready_i low, in_ready_o is low.
// ----------------------------------------------------------------------------
`default_nettype none

`include "grouped_sorted_list_engine_defines.svh"

module grouped_sorted_list_engine #(
  parameter int unsigned NUM_GROUPS     = gsle_pkg::NUM_GROUPS_DEF,
  parameter int unsigned GROUP_CAPACITY = gsle_pkg::GROUP_CAPACITY_DEF,
  parameter int unsigned CODE_BITS      = gsle_pkg::CODE_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic                               req_type_i,
  input  wire logic [gsle_pkg::GROUP_SEL_W-1:0]   group_sel_i,
  input  wire logic [gsle_pkg::CODE_VAL_W-1:0]    code_value_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic                                    status_o,
  output logic [gsle_pkg::REMOVED_W-1:0]          removed_count_o,
  output logic [gsle_pkg::FILL_W-1:0]             group_fill_o
);

  localparam int unsigned CNT_W = $clog2(GROUP_CAPACITY + 1);

  logic                        accept;
  logic                        is_ins, is_rem, grp_ok;
  logic [31:0]                 code_ext;
  logic [CODE_BITS-1:0]        code;
  logic [NUM_GROUPS-1:0]       ins_sel;
  gsle_pkg::row_stat_t         stat  [NUM_GROUPS];
  logic [CNT_W-1:0]            count [NUM_GROUPS];
  logic [NUM_GROUPS-1:0]       hits;
  logic                        sel_full;
  logic [CNT_W-1:0]            sel_count;

  logic                               out_valid_q, out_valid_d;
  logic                               status_q, status_d;
  logic [gsle_pkg::REMOVED_W-1:0]     removed_q, removed_d;
  logic [gsle_pkg::FILL_W-1:0]        fill_q, fill_d;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_ins     = accept && (req_type_i == gsle_pkg::REQ_INSERT);
  assign is_rem     = accept && (req_type_i == gsle_pkg::REQ_REMOVE);
  assign grp_ok     = (32'(group_sel_i) < NUM_GROUPS);
  assign code_ext   = 32'(code_value_i);
  assign code       = code_ext[CODE_BITS-1:0];

  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_row
    assign ins_sel[g] = is_ins && (32'(group_sel_i) == g);
    assign hits[g]    = stat[g].hit;
    gsle_row #(
      .GROUP_CAPACITY(GROUP_CAPACITY),
      .CODE_BITS     (CODE_BITS)
    ) u_row (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ins_i   (ins_sel[g]),
      .rem_i   (is_rem),
      .code_i  (code),
      .stat_o  (stat[g]),
      .count_o (count[g])
    );
  end

  always_comb begin
    sel_full  = 1'b0;
    sel_count = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      if (32'(group_sel_i) == g) begin
        sel_full  = stat[g].full;
        sel_count = count[g];
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    status_d    = status_q;
    removed_d   = removed_q;
    fill_d      = fill_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      out_valid_d = 1'b1;
      status_d    = gsle_pkg::ST_DONE;
      removed_d   = '0;
      fill_d      = '0;
      if (req_type_i == gsle_pkg::REQ_REMOVE) begin
        removed_d = gsle_pkg::REMOVED_W'($countones(hits));
      end else if (grp_ok) begin
        if (sel_full) begin
          status_d = gsle_pkg::ST_FULL;
          fill_d   = gsle_pkg::FILL_W'(sel_count);
        end else begin
          fill_d   = gsle_pkg::FILL_W'(sel_count + CNT_W'(1));
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    removed_q <= removed_d;
    fill_q    <= fill_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign removed_count_o = removed_q;
  assign group_fill_o    = fill_q;

  `GSLE_ASSERT_NEXT(a_rem_result, is_rem, (status_o == gsle_pkg::ST_DONE) && (group_fill_o == '0))
  `GSLE_ASSERT_NEXT(a_ins_no_removed, is_ins, removed_count_o == '0)
  `GSLE_ASSERT(a_full_fill, out_valid_o && (status_o == gsle_pkg::ST_FULL), group_fill_o == gsle_pkg::FILL_W'(GROUP_CAPACITY))

endmodule

`default_nettype wire

// ===== hdl/gsle_cell.sv =====
// ----------------------------------------------------------------------------
// gsle_cell
// One slot of a sorted group: holds a code and an occupied flag, shifts
// right on insert and left on remove.
// ----------------------------------------------------------------------------
`default_nettype none

module gsle_cell #(
  parameter int unsigned CODE_BITS = gsle_pkg::CODE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire gsle_pkg::cell_ctl_t   ctl_i,
  input  wire logic [CODE_BITS-1:0]  code_i,
  input  wire logic [CODE_BITS-1:0]  left_val_i,
  input  wire logic                  left_occ_i,
  input  wire logic                  left_le_i,
  input  wire logic [CODE_BITS-1:0]  right_val_i,
  input  wire logic                  right_occ_i,
  output logic [CODE_BITS-1:0]       val_o,
  output logic                       occ_o,
  output logic                       le_o,
  output logic                       match_o
);

  logic [CODE_BITS-1:0] val_q, val_d;
  logic                 occ_q, occ_d;
  logic                 le;

  // le is monotone along a sorted row: false on the prefix below code
  assign le      = !occ_q || (code_i <= val_q);
  assign match_o = occ_q && (val_q == code_i);
  assign le_o    = le;
  assign val_o   = val_q;
  assign occ_o   = occ_q;

  always_comb begin
    val_d = val_q;
    occ_d = occ_q;
    if (ctl_i.ins_en) begin
      if (left_le_i) begin
        val_d = left_val_i;
        occ_d = left_occ_i;
      end else if (le) begin
        val_d = code_i;
        occ_d = 1'b1;
      end
    end else if (ctl_i.rem_en && le) begin
      val_d = right_val_i;
      occ_d = right_occ_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

`default_nettype wire

// ===== hdl/gsle_row.sv =====
// ----------------------------------------------------------------------------
// gsle_row
// One group: a chain of cells kept in ascending order, plus its fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module gsle_row #(
  parameter int unsigned GROUP_CAPACITY = gsle_pkg::GROUP_CAPACITY_DEF,
  parameter int unsigned CODE_BITS      = gsle_pkg::CODE_BITS_DEF,
  localparam int unsigned CNT_W         = $clog2(GROUP_CAPACITY + 1)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 ins_i,
  input  wire logic                 rem_i,
  input  wire logic [CODE_BITS-1:0] code_i,
  output gsle_pkg::row_stat_t       stat_o,
  output logic [CNT_W-1:0]          count_o
);

  logic [CNT_W-1:0]     count_q, count_d;
  gsle_pkg::cell_ctl_t  ctl;
  logic [CODE_BITS-1:0] val   [GROUP_CAPACITY];
  logic                 occ   [GROUP_CAPACITY];
  logic                 le    [GROUP_CAPACITY];
  logic [GROUP_CAPACITY-1:0] match;
  logic                 full;
  logic                 hit;

  assign full       = (count_q >= CNT_W'(GROUP_CAPACITY));
  assign hit        = |match;
  assign ctl.ins_en = ins_i && !full;
  assign ctl.rem_en = rem_i && hit;
  assign stat_o.full = full;
  assign stat_o.hit  = hit;
  assign count_o     = count_q;

  for (genvar i = 0; i < GROUP_CAPACITY; i++) begin : g_cell
    logic [CODE_BITS-1:0] lv, rv;
    logic                 lo, ll, ro;
    if (i == 0) begin : g_first
      assign lv = '0;
      assign lo = 1'b0;
      assign ll = 1'b0;
    end else begin : g_mid_l
      assign lv = val[i-1];
      assign lo = occ[i-1];
      assign ll = le[i-1];
    end
    if (i == GROUP_CAPACITY - 1) begin : g_last
      assign rv = '0;
      assign ro = 1'b0;
    end else begin : g_mid_r
      assign rv = val[i+1];
      assign ro = occ[i+1];
    end
    gsle_cell #(
      .CODE_BITS(CODE_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .code_i      (code_i),
      .left_val_i  (lv),
      .left_occ_i  (lo),
      .left_le_i   (ll),
      .right_val_i (rv),
      .right_occ_i (ro),
      .val_o       (val[i]),
      .occ_o       (occ[i]),
      .le_o        (le[i]),
      .match_o     (match[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctl.ins_en) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctl.rem_en) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire
